// File: sv/dbtu_pkg.sv
// Package for the depth buffer test unit: operation codes, register indexes,
// the clear-walker request type and fixed field widths.
// Depends on nothing; dbtu_sweep, the top level and the testbench use it.
`default_nettype none

package dbtu_pkg;

    // Operation carried in the tuser field of an input transaction.
    typedef enum logic [1:0] {
        FUNC_TEST  = 2'd0,
        FUNC_SET   = 2'd1,
        FUNC_GET   = 2'd2,
        FUNC_CLEAR = 2'd3
    } t_func;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 8'd1;

    // Frame size registers and their reset value.
    localparam int FRAME_W = 9;
    localparam logic [FRAME_W-1:0] FRAME_RESET = 9'd256;

    // Width used for column and row counts, enough for sizes up to 8191.
    localparam int SIZE_W = 13;

    // Request from the item pipeline to the clear walker.
    typedef struct packed {
        logic              start;
        logic [SIZE_W-1:0] cols;
        logic [SIZE_W-1:0] rows;
    } t_sweep_req;

endpackage

`default_nettype wire

// File: sv/dbtu_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing. A read of the address being written returns the old data.
`default_nettype none

module dbtu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/dbtu_sweep.sv
// Clear walker: steps through the active frame, one depth entry per cycle.
// Depends on dbtu_pkg. After reset it walks the whole store once.
`default_nettype none

module dbtu_sweep #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int ADDR_W     = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire dbtu_pkg::t_sweep_req i_req,
    output logic                     o_busy,
    output logic [ADDR_W-1:0]        o_addr
);

    logic                        r_busy;
    logic [dbtu_pkg::SIZE_W-1:0] r_cols;
    logic [dbtu_pkg::SIZE_W-1:0] r_rows;
    logic [dbtu_pkg::SIZE_W-1:0] r_col;
    logic [dbtu_pkg::SIZE_W-1:0] r_row;
    logic [ADDR_W-1:0]           r_base;
    logic                        last_col;
    logic                        last_row;

    assign last_col = (r_col == r_cols - dbtu_pkg::SIZE_W'(1));
    assign last_row = (r_row == r_rows - dbtu_pkg::SIZE_W'(1));

    // Walk columns within a row, then move the row base by one stored row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cols <= dbtu_pkg::SIZE_W'(MAX_WIDTH);
            r_rows <= dbtu_pkg::SIZE_W'(MAX_HEIGHT);
            r_col  <= '0;
            r_row  <= '0;
            r_base <= '0;
        end else if (r_busy) begin
            if (last_col) begin
                r_col <= '0;
                if (last_row) begin
                    r_busy <= 1'b0;
                    r_row  <= '0;
                    r_base <= '0;
                end else begin
                    r_row  <= r_row + dbtu_pkg::SIZE_W'(1);
                    r_base <= r_base + ADDR_W'(MAX_WIDTH);
                end
            end else begin
                r_col <= r_col + dbtu_pkg::SIZE_W'(1);
            end
        end else if (i_req.start && (i_req.cols != '0) && (i_req.rows != '0)) begin
            r_busy <= 1'b1;
            r_cols <= i_req.cols;
            r_rows <= i_req.rows;
            r_col  <= '0;
            r_row  <= '0;
            r_base <= '0;
        end
    end

    assign o_busy = r_busy;
    assign o_addr = r_base + ADDR_W'(r_col);

endmodule

`default_nettype wire

// File: sv/depth_buffer_test_unit.sv
// Top level of the depth buffer test unit: stream ports, frame registers,
// the read-modify-write stage and the output register.
// Depends on dbtu_pkg, dbtu_ram and dbtu_sweep.
`default_nettype none

// A z-buffer holding one signed fixed-point depth per pixel (1.0 is
// 2^(DEPTH_BITS-2)) in a single RAM with a registered read port. Depth test,
// set and get items are accepted one per cycle while results are taken: an
// item reads the RAM in the cycle it is accepted, is compared and written back
// in the item stage and is registered for output once the output register is
// free or drains, with the pending write forwarded to a following item on the
// same pixel. Each item gives exactly one result. A clear item stops input
// while the walker refills the active frame with 1.0, one entry per cycle.
// After reset the walker fills all MAX_WIDTH * MAX_HEIGHT entries (65536 at
// the defaults) with 1.0 before the first item is accepted. Frame registers
// may be written at any time through the configuration channel but should
// change only while the block is idle.
module depth_buffer_test_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int DEPTH_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_data,
    // Input stream.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata: pixel_x [10:0], pixel_y [21:11], depth_value [37:22], zero [39:38]
    input  wire logic [39:0] i_s_axis_tdata,
    // tuser: func [1:0]
    input  wire logic [1:0]  i_s_axis_tuser,
    // Result stream.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // tdata: in_front [0], read_depth [16:1], zero [23:17]
    output logic [23:0]      o_m_axis_tdata
);

    localparam int RAM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam int WB        = (DEPTH_BITS > 16) ? DEPTH_BITS : 16;
    localparam int AFW       = 24;

    localparam logic signed [DEPTH_BITS-1:0] DEPTH_ONE =
        {2'b01, {(DEPTH_BITS-2){1'b0}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_NEG_ONE =
        {2'b11, {(DEPTH_BITS-2){1'b0}}};

    // Frame size registers.
    logic [dbtu_pkg::FRAME_W-1:0] r_frame_width;
    logic [dbtu_pkg::FRAME_W-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= dbtu_pkg::FRAME_RESET;
            r_frame_height <= dbtu_pkg::FRAME_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == dbtu_pkg::CFG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_data;
            end else if (i_cfg_index == dbtu_pkg::CFG_FRAME_HEIGHT) begin
                r_frame_height <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    // Input field unpacking.
    dbtu_pkg::t_func        in_func;
    logic [10:0]            in_x;
    logic [10:0]            in_y;
    logic signed [15:0]     in_depth;
    logic signed [WB-1:0]   in_depth_ext;
    logic signed [DEPTH_BITS-1:0] in_z;

    assign in_func      = dbtu_pkg::t_func'(i_s_axis_tuser);
    assign in_x         = i_s_axis_tdata[10:0];
    assign in_y         = i_s_axis_tdata[21:11];
    assign in_depth     = $signed(i_s_axis_tdata[37:22]);
    assign in_depth_ext = WB'(in_depth);
    assign in_z         = in_depth_ext[DEPTH_BITS-1:0];

    // Bounds check and store address of the incoming pixel.
    logic              in_x_ok;
    logic              in_y_ok;
    logic              in_inb;
    logic [ADDR_W-1:0] in_addr;

    assign in_x_ok = !in_x[10]
        && (dbtu_pkg::SIZE_W'(in_x[9:0]) < dbtu_pkg::SIZE_W'(r_frame_width))
        && (dbtu_pkg::SIZE_W'(in_x[9:0]) < dbtu_pkg::SIZE_W'(MAX_WIDTH));
    assign in_y_ok = !in_y[10]
        && (dbtu_pkg::SIZE_W'(in_y[9:0]) < dbtu_pkg::SIZE_W'(r_frame_height))
        && (dbtu_pkg::SIZE_W'(in_y[9:0]) < dbtu_pkg::SIZE_W'(MAX_HEIGHT));
    assign in_inb  = in_x_ok && in_y_ok;
    assign in_addr = ADDR_W'(AFW'(in_y[9:0]) * AFW'(MAX_WIDTH) + AFW'(in_x[9:0]));

    // Read-modify-write stage registers.
    logic                         r_a_valid;
    dbtu_pkg::t_func              r_a_func;
    logic [ADDR_W-1:0]            r_a_addr;
    logic                         r_a_inb;
    logic signed [DEPTH_BITS-1:0] r_a_z;
    logic                         r_a_fwd;
    logic signed [DEPTH_BITS-1:0] r_a_fwd_data;

    // Output register.
    logic        r_o_valid;
    logic        r_o_front;
    logic [15:0] r_o_rd;

    // Memory and clear walker connections.
    logic [DEPTH_BITS-1:0]        ram_rdata;
    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    logic [DEPTH_BITS-1:0]        ram_wdata;
    logic                         sweep_busy;
    logic [ADDR_W-1:0]            sweep_addr;
    dbtu_pkg::t_sweep_req         sweep_req;

    // Stage compute: compare against the stored or forwarded depth.
    logic signed [DEPTH_BITS-1:0] a_stored;
    logic                         a_pass;
    logic                         a_we;
    logic signed [DEPTH_BITS-1:0] a_rd;
    logic signed [WB-1:0]         a_rd_ext;
    logic                         a_adv;
    logic                         s_accept;
    logic                         n_fwd;

    assign a_stored = r_a_fwd ? r_a_fwd_data : $signed(ram_rdata);
    assign a_pass   = r_a_inb && (r_a_z < a_stored)
                      && (r_a_z > DEPTH_NEG_ONE) && (r_a_z < DEPTH_ONE);

    always_comb begin
        a_we = 1'b0;
        a_rd = '0;
        case (r_a_func)
            dbtu_pkg::FUNC_TEST: a_we = r_a_valid && a_pass;
            dbtu_pkg::FUNC_SET:  a_we = r_a_valid && r_a_inb;
            dbtu_pkg::FUNC_GET:  a_rd = r_a_inb ? a_stored : DEPTH_NEG_ONE;
            default:             a_we = 1'b0;
        endcase
    end

    assign a_rd_ext = WB'(a_rd);

    // Handshake: the stage moves on when the output register is free or drains.
    assign a_adv           = r_a_valid && (!r_o_valid || i_m_axis_tready);
    assign o_s_axis_tready = !sweep_busy
        && (!r_a_valid || (a_adv && (r_a_func != dbtu_pkg::FUNC_CLEAR)));
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign n_fwd           = a_we && (r_a_addr == in_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (s_accept) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_a_func     <= in_func;
            r_a_addr     <= in_addr;
            r_a_inb      <= in_inb;
            r_a_z        <= in_z;
            r_a_fwd      <= n_fwd;
            r_a_fwd_data <= r_a_z;
        end
    end

    // Result register toward the output stream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (a_adv) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_o_front <= (r_a_func == dbtu_pkg::FUNC_TEST) && a_pass;
            r_o_rd    <= a_rd_ext[15:0];
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {7'b0, r_o_rd, r_o_front};

    // Clear request with the active frame size, each limited to its maximum.
    logic [dbtu_pkg::SIZE_W-1:0] act_cols;
    logic [dbtu_pkg::SIZE_W-1:0] act_rows;

    assign act_cols = (dbtu_pkg::SIZE_W'(r_frame_width) < dbtu_pkg::SIZE_W'(MAX_WIDTH))
        ? dbtu_pkg::SIZE_W'(r_frame_width) : dbtu_pkg::SIZE_W'(MAX_WIDTH);
    assign act_rows = (dbtu_pkg::SIZE_W'(r_frame_height) < dbtu_pkg::SIZE_W'(MAX_HEIGHT))
        ? dbtu_pkg::SIZE_W'(r_frame_height) : dbtu_pkg::SIZE_W'(MAX_HEIGHT);

    assign sweep_req.start = a_adv && (r_a_func == dbtu_pkg::FUNC_CLEAR);
    assign sweep_req.cols  = act_cols;
    assign sweep_req.rows  = act_rows;

    dbtu_sweep #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sweep_req),
        .o_busy  (sweep_busy),
        .o_addr  (sweep_addr)
    );

    // Write port: the walker owns it while busy, the item stage otherwise.
    assign ram_we    = sweep_busy || a_we;
    assign ram_waddr = sweep_busy ? sweep_addr : r_a_addr;
    assign ram_wdata = sweep_busy ? DEPTH_ONE : r_a_z;

    dbtu_ram #(
        .WIDTH (DEPTH_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (s_accept),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the depth buffer test unit: drives fragments and frame
// size writes, predicts every result and compares it on the output stream.
// Depends on dbtu_pkg and depth_buffer_test_unit.
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_W = 256;
    localparam int MAX_H = 256;
    localparam int ZBUF_ENTRIES = MAX_W * MAX_H;
    localparam int DEPTH_ONE = 16384;
    localparam int STALL_LIMIT = 250000;
    localparam int NUM_PHASES = 8;
    localparam logic [dbtu_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 8'd2;

    // One fragment as it travels on the input stream.
    typedef struct {
        dbtu_pkg::t_func    func;
        logic signed [10:0] px;
        logic signed [10:0] py;
        logic signed [15:0] depth;
        bit                 wait_drain;
    } t_fragment;

    // One result as it travels on the output stream.
    typedef struct {
        bit                 in_front;
        logic signed [15:0] read_depth;
    } t_zresult;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_index = '0;
    logic [8:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    wire         o_cfg_ready;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [23:0] o_m_axis_tdata;

    depth_buffer_test_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        // tdata: pixel_x [10:0], pixel_y [21:11], depth_value [37:22], zero [39:38]
        .i_s_axis_tdata  (s_tdata),
        // tuser: func [1:0]
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        // tdata: in_front [0], read_depth [16:1], zero [23:17]
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Free-running 100 MHz clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow z-buffer and frame registers used for prediction.
    logic signed [15:0] zbuf_model [ZBUF_ENTRIES];
    logic [8:0]         model_w = dbtu_pkg::FRAME_RESET;
    logic [8:0]         model_h = dbtu_pkg::FRAME_RESET;

    t_fragment fragment_queue [$];
    t_zresult  expected_depth_results [$];
    t_fragment in_flight;
    logic      frag_taken = 1'b0;

    int pushed_cnt = 0;
    int accepted_cnt = 0;
    int results_checked = 0;
    int error_cnt = 0;
    int walk_cycles = 0;
    int clears_seen = 0;
    int fronts_passed = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int stall_cycles = 0;

    function automatic int active_cols();
        return (model_w > MAX_W) ? MAX_W : int'(model_w);
    endfunction

    function automatic int active_rows();
        return (model_h > MAX_H) ? MAX_H : int'(model_h);
    endfunction

    // Applies one fragment to the shadow z-buffer and returns the result it must give.
    function automatic t_zresult predict_zbuf_op(t_fragment f);
        t_zresult r;
        int xi;
        int yi;
        int aw;
        int ah;
        int idx;
        bit hit;
        r.in_front = 1'b0;
        r.read_depth = '0;
        aw = active_cols();
        ah = active_rows();
        xi = f.px;
        yi = f.py;
        hit = (xi >= 0) && (yi >= 0) && (xi < aw) && (yi < ah);
        idx = hit ? yi * MAX_W + xi : 0;
        case (f.func)
            dbtu_pkg::FUNC_TEST: begin
                if (hit && f.depth < zbuf_model[idx] && f.depth > -DEPTH_ONE
                        && f.depth < DEPTH_ONE) begin
                    zbuf_model[idx] = f.depth;
                    r.in_front = 1'b1;
                end
            end
            dbtu_pkg::FUNC_SET: begin
                if (hit) zbuf_model[idx] = f.depth;
            end
            dbtu_pkg::FUNC_GET: begin
                r.read_depth = hit ? zbuf_model[idx] : 16'(-DEPTH_ONE);
            end
            default: begin
                // The refill touches only the active frame.
                for (int row = 0; row < ah; row++)
                    for (int col = 0; col < aw; col++)
                        zbuf_model[row * MAX_W + col] = 16'(DEPTH_ONE);
                if (aw * ah > walk_cycles) walk_cycles = aw * ah;
                clears_seen++;
            end
        endcase
        fronts_passed += r.in_front;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        error_cnt++;
        $display("tb_top: MISMATCH at %0t: %s", $time, msg);
    endtask

    // Input driver: presents the next fragment when the slot is free.
    always @(negedge i_clk) begin
        bit slot_free;
        bit go;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            slot_free = !s_tvalid || frag_taken;
            if (slot_free) begin
                go = (fragment_queue.size() != 0) && ($urandom_range(99) >= send_idle_pct);
                // A draining fragment holds until every pending result has come back.
                if (go && fragment_queue[0].wait_drain && expected_depth_results.size() != 0)
                    go = 1'b0;
                if (go) begin
                    in_flight = fragment_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, in_flight.depth, in_flight.py, in_flight.px};
                    s_tuser  <= in_flight.func;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver back-pressure.
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: checks each result transaction, then predicts each input transaction.
    always @(posedge i_clk) begin
        t_zresult exp_r;
        if (!i_rst_n) begin
            frag_taken <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                results_checked++;
                if (expected_depth_results.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    exp_r = expected_depth_results.pop_front();
                    if (o_m_axis_tdata[0] !== exp_r.in_front)
                        report_mismatch($sformatf("in_front got %b expected %b",
                            o_m_axis_tdata[0], exp_r.in_front));
                    if (o_m_axis_tdata[16:1] !== exp_r.read_depth)
                        report_mismatch($sformatf("read_depth got %0d expected %0d",
                            $signed(o_m_axis_tdata[16:1]), exp_r.read_depth));
                end
            end
            frag_taken <= s_tvalid && o_s_axis_tready;
            if (s_tvalid && o_s_axis_tready) begin
                expected_depth_results.push_back(predict_zbuf_op(in_flight));
                accepted_cnt++;
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)
                || (cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top: no transaction for %0d cycles", STALL_LIMIT);
            $display("tb_top: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_frame_reg(input logic [7:0] index, input logic [8:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == dbtu_pkg::CFG_FRAME_WIDTH) model_w = value;
        else if (index == dbtu_pkg::CFG_FRAME_HEIGHT) model_h = value;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_frag(input dbtu_pkg::t_func fn, input int x, input int y,
                             input int z, input bit drain);
        t_fragment f;
        f.func = fn;
        f.px = 11'(x);
        f.py = 11'(y);
        f.depth = 16'(z);
        f.wait_drain = drain;
        fragment_queue.push_back(f);
        pushed_cnt++;
    endtask

    // Waits until the block has nothing outstanding, including a running frame refill.
    task automatic settle_block();
        while (accepted_cnt != pushed_cnt || expected_depth_results.size() != 0)
            @(posedge i_clk);
        repeat (walk_cycles + 8) @(posedge i_clk);
        walk_cycles = 0;
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
        endcase
    endtask

    function automatic int pick_depth();
        int roll;
        logic [31:0] raw;
        roll = $urandom_range(99);
        raw = $urandom();
        if (roll < 50) return int'($urandom_range(32766)) - (DEPTH_ONE - 1);
        if (roll < 65) begin
            case ($urandom_range(6))
                0: return DEPTH_ONE;
                1: return -DEPTH_ONE;
                2: return DEPTH_ONE - 1;
                3: return 1 - DEPTH_ONE;
                4: return 0;
                5: return -32768;
                default: return 32767;
            endcase
        end
        return int'($signed(raw[15:0]));
    endfunction

    // Mostly near the active frame, sometimes anywhere in the signed range.
    function automatic int pick_coord(input int lim);
        logic [31:0] raw;
        raw = $urandom();
        if ($urandom_range(99) < 20) return int'($signed(raw[10:0]));
        return int'($urandom_range(lim + 3)) - 2;
    endfunction

    // Random fragments: mostly short runs on one pixel, the rest scattered noise.
    task automatic fill_random_phase(input int count);
        int made;
        int aw;
        int ah;
        int x;
        int y;
        int run_len;
        dbtu_pkg::t_func fn;
        made = 0;
        aw = active_cols();
        ah = active_rows();
        while (made < count) begin
            if ($urandom_range(99) < 70) begin
                if (aw > 0 && ah > 0 && $urandom_range(99) < 85) begin
                    if ($urandom_range(1) == 0) begin
                        x = $urandom_range(((aw < 4) ? aw : 4) - 1);
                        y = $urandom_range(((ah < 4) ? ah : 4) - 1);
                    end else begin
                        x = $urandom_range(aw - 1);
                        y = $urandom_range(ah - 1);
                    end
                end else begin
                    x = pick_coord(aw);
                    y = pick_coord(ah);
                end
                run_len = $urandom_range(5, 2);
                for (int k = 0; k < run_len; k++) begin
                    if (k == run_len - 1) fn = dbtu_pkg::FUNC_GET;
                    else if (k == 0 && $urandom_range(1) == 0) fn = dbtu_pkg::FUNC_SET;
                    else fn = dbtu_pkg::FUNC_TEST;
                    push_frag(fn, x, y, pick_depth(), made == count / 2);
                    made++;
                end
            end else begin
                fn = dbtu_pkg::t_func'($urandom_range(3));
                if (fn == dbtu_pkg::FUNC_CLEAR && (aw * ah > 2048 || $urandom_range(99) < 80))
                    fn = dbtu_pkg::FUNC_GET;
                push_frag(fn, pick_coord(aw), pick_coord(ah), pick_depth(),
                          made == count / 2);
                made++;
            end
        end
    endtask

    // Main sequence: reset, directed fragments, then random phases over frame sizes.
    initial begin
        int phase_w [NUM_PHASES];
        int phase_h [NUM_PHASES];
        phase_w = '{1, 12, 0, 511, 7, 256, 20, 256};
        phase_h = '{1, 9, 5, 2, 300, 1, 20, 256};
        for (int i = 0; i < ZBUF_ENTRIES; i++) zbuf_model[i] = 16'(DEPTH_ONE);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: bounds, strict comparisons, the open interval, set, get and clear.
        push_frag(dbtu_pkg::FUNC_GET, 0, 0, 0, 1'b0);
        push_frag(dbtu_pkg::FUNC_GET, MAX_W - 1, MAX_H - 1, 0, 1'b0);
        push_frag(dbtu_pkg::FUNC_GET, MAX_W, 0, 0, 1'b0);
        push_frag(dbtu_pkg::FUNC_GET, 0, -1, 0, 1'b0);
        push_frag(dbtu_pkg::FUNC_GET, -1024, 1023, -1, 1'b0);
        push_frag(dbtu_pkg::FUNC_TEST, 0, 0, DEPTH_ONE, 1'b1);
        push_frag(dbtu_pkg::FUNC_TEST, 0, 0, DEPTH_ONE - 1, 1'b0);
        push_frag(dbtu_pkg::FUNC_TEST, 0, 0, DEPTH_ONE - 1, 1'b0);
        push_frag(dbtu_pkg::FUNC_TEST, 0, 0, -DEPTH_ONE, 1'b0);
        push_frag(dbtu_pkg::FUNC_TEST, 0, 0, 1 - DEPTH_ONE, 1'b0);
        push_frag(dbtu_pkg::FUNC_GET, 0, 0, 0, 1'b0);
        push_frag(dbtu_pkg::FUNC_SET, 5, 5, -32768, 1'b0);
        push_frag(dbtu_pkg::FUNC_GET, 5, 5, 0, 1'b0);
        push_frag(dbtu_pkg::FUNC_TEST, 5, 5, 0, 1'b0);
        push_frag(dbtu_pkg::FUNC_SET, 5, 5, 32767, 1'b0);
        push_frag(dbtu_pkg::FUNC_TEST, 5, 5, 0, 1'b0);
        push_frag(dbtu_pkg::FUNC_SET, MAX_W, 3, 0, 1'b0);
        push_frag(dbtu_pkg::FUNC_GET, MAX_W - 1, 3, 0, 1'b0);
        push_frag(dbtu_pkg::FUNC_TEST, -1, 0, 0, 1'b0);
        push_frag(dbtu_pkg::FUNC_TEST, 1023, MAX_H - 1, 0, 1'b0);
        push_frag(dbtu_pkg::FUNC_CLEAR, 0, 0, 0, 1'b0);
        push_frag(dbtu_pkg::FUNC_GET, 0, 0, 0, 1'b0);
        push_frag(dbtu_pkg::FUNC_GET, 5, 5, 0, 1'b0);
        settle_block();

        // An index past the two registers must leave the frame size alone.
        write_frame_reg(CFG_UNUSED_INDEX, 9'd3);
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_frame_reg(dbtu_pkg::CFG_FRAME_WIDTH, 9'(phase_w[p]));
            write_frame_reg(dbtu_pkg::CFG_FRAME_HEIGHT, 9'(phase_h[p]));
            set_idling(p);
            fill_random_phase((phase_w[p] == 0) ? 40 : 145);
            settle_block();
        end

        $display("tb_top: %0d fragments over %0d frame sizes, %0d results checked",
                 accepted_cnt, NUM_PHASES + 1, results_checked);
        $display("tb_top: %0d clears, %0d depth tests passed, %0d mismatches",
                 clears_seen, fronts_passed, error_cnt);
        if (error_cnt == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/dbtu_pkg.sv
sv/dbtu_ram.sv
sv/dbtu_sweep.sv
sv/depth_buffer_test_unit.sv
sim/tb_top.sv
